[src/rtpdtmf_pkg.sv]
// ----------------------------------------------------------------------------
// rtpdtmf_pkg
// shared types, register codes and constants of the telephony event generator
// ----------------------------------------------------------------------------
package rtpdtmf_pkg;

  // command queue between front and back
  localparam int CMD_DEPTH = 4;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAYLOAD_TYPE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SEND_INTERVAL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_END_COUNT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DURATION  = 3'd4;

  localparam logic        RST_ENABLE        = 1'b0;
  localparam logic [6:0]  RST_PAYLOAD_TYPE  = 7'd0;
  localparam logic [9:0]  RST_SEND_INTERVAL = 10'd50;
  localparam logic [3:0]  RST_END_COUNT     = 4'd3;
  localparam logic [12:0] RST_MAX_DURATION  = 13'd8191;

  // item operations
  localparam logic OP_START = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // elapsed time used when the clock ran backwards
  localparam logic [15:0] ELAPSED_BACKWARD_MS = 16'd20;
  // 8 samples per millisecond
  localparam int SAMPLE_SHIFT = 3;

  typedef struct packed {
    logic        enable;
    logic [6:0]  payload_type;
    logic [9:0]  send_interval;
    logic [3:0]  end_count;
    logic [12:0] max_duration;
  } cfg_t;

  // one formed packet and its copy count
  typedef struct packed {
    logic [7:0]  event_code;
    logic        end_flag;
    logic [5:0]  volume;
    logic [15:0] duration_samples;
    logic [31:0] timestamp;
    logic        marker;
    logic [6:0]  payload_type;
    logic [3:0]  copies;
  } pkt_cmd_t;

  // one result item
  typedef struct packed {
    logic [7:0]  event_code;
    logic        end_flag;
    logic [5:0]  volume;
    logic [15:0] duration_samples;
    logic [31:0] timestamp;
    logic        marker;
    logic [6:0]  payload_type;
    logic        last;
  } out_pkt_t;

endpackage

[src/rtpdtmf_front.sv]
// ----------------------------------------------------------------------------
// rtpdtmf_front
// event state, interval and end tests, at most one packet command per item
// ----------------------------------------------------------------------------
module rtpdtmf_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rtpdtmf_pkg::cfg_t     cfg,
  input  logic                  take,
  input  logic                  in_operation,
  input  logic [7:0]            in_digit,
  input  logic [15:0]           in_duration_ms,
  input  logic [5:0]            in_volume,
  input  logic [31:0]           in_now_ms,
  input  logic [31:0]           in_rtp_timestamp,
  output logic                  push,
  output rtpdtmf_pkg::pkt_cmd_t cmd
);
  import rtpdtmf_pkg::*;

  logic        active_r, active_nxt;
  logic        first_pending_r, first_pending_nxt;
  logic [7:0]  held_digit_r;
  logic [5:0]  held_volume_r;
  logic [15:0] held_duration_r;
  logic [31:0] start_time_r;
  logic [31:0] end_time_r;
  logic [31:0] event_ts_r;
  logic [31:0] last_send_r;

  logic        is_start;
  logic [15:0] dur_clamped;
  logic [31:0] diff_fwd, diff_bwd, mag;
  logic        interval_ok;
  logic        end_reached;
  logic [31:0] since_start;
  logic [15:0] elapsed;
  logic        force_end;
  logic        is_end;
  logic [15:0] elapsed_sel;
  logic [3:0]  copies;
  logic        emit;
  logic        send_tick;

  assign is_start    = (in_operation == OP_START);
  assign dur_clamped = (in_duration_ms > {3'b000, cfg.max_duration})
                       ? {3'b000, cfg.max_duration} : in_duration_ms;

  // magnitude of the signed distance to the last send
  assign diff_fwd    = in_now_ms - last_send_r;
  assign diff_bwd    = last_send_r - in_now_ms;
  assign mag         = diff_fwd[31] ? diff_bwd : diff_fwd;
  assign interval_ok = (mag >= {22'd0, cfg.send_interval});
  assign end_reached = (end_time_r <= in_now_ms);

  assign since_start = in_now_ms - start_time_r;
  assign elapsed     = (in_now_ms < start_time_r) ? ELAPSED_BACKWARD_MS : since_start[15:0];

  assign force_end   = is_start || end_reached;
  assign is_end      = force_end || (elapsed >= held_duration_r);
  assign elapsed_sel = is_end ? held_duration_r : elapsed;
  assign copies      = is_end ? cfg.end_count : 4'd1;

  assign send_tick   = take && active_r && !is_start && interval_ok;
  assign emit        = take && active_r && (is_start || interval_ok);

  assign push = emit && cfg.enable && (copies != 4'd0);

  always_comb begin
    cmd.event_code       = held_digit_r;
    cmd.end_flag         = is_end;
    cmd.volume           = held_volume_r;
    cmd.duration_samples = 16'(elapsed_sel << SAMPLE_SHIFT);
    cmd.timestamp        = event_ts_r;
    cmd.marker           = first_pending_r;
    cmd.payload_type     = cfg.payload_type;
    cmd.copies           = copies;
  end

  always_comb begin
    active_nxt        = active_r;
    first_pending_nxt = first_pending_r;
    if (emit && cfg.enable) begin
      first_pending_nxt = 1'b0;
    end
    if (send_tick && end_reached) begin
      active_nxt = 1'b0;
    end
    if (take && is_start) begin
      active_nxt        = 1'b1;
      first_pending_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r        <= 1'b0;
      first_pending_r <= 1'b0;
      held_digit_r    <= '0;
      held_volume_r   <= '0;
      held_duration_r <= '0;
      start_time_r    <= '0;
      end_time_r      <= '0;
      event_ts_r      <= '0;
      last_send_r     <= '0;
    end else begin
      active_r        <= active_nxt;
      first_pending_r <= first_pending_nxt;
      if (take && is_start) begin
        held_digit_r    <= in_digit;
        held_volume_r   <= in_volume;
        held_duration_r <= dur_clamped;
        start_time_r    <= in_now_ms;
        end_time_r      <= in_now_ms + {16'd0, dur_clamped};
        event_ts_r      <= in_rtp_timestamp;
      end
      if (send_tick) begin
        last_send_r <= in_now_ms;
      end
    end
  end

endmodule

[src/rtpdtmf_queue.sv]
// ----------------------------------------------------------------------------
// rtpdtmf_queue
// short command queue between front and back
// ----------------------------------------------------------------------------
module rtpdtmf_queue #(
  parameter int DEPTH = rtpdtmf_pkg::CMD_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  rtpdtmf_pkg::pkt_cmd_t wr_data,
  input  logic                  pop,
  output rtpdtmf_pkg::pkt_cmd_t rd_data,
  output logic                  full,
  output logic                  empty
);
  import rtpdtmf_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  pkt_cmd_t           slots_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

[src/rtpdtmf_back.sv]
// ----------------------------------------------------------------------------
// rtpdtmf_back
// expands each command into its copies and holds the result register
// ----------------------------------------------------------------------------
module rtpdtmf_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rtpdtmf_pkg::pkt_cmd_t q_data,
  input  logic                  q_empty,
  output logic                  q_pop,
  input  logic                  out_take,
  output logic                  out_valid,
  output rtpdtmf_pkg::out_pkt_t out_pkt
);
  import rtpdtmf_pkg::*;

  pkt_cmd_t   cmd_r;
  logic [3:0] rem_r, rem_nxt;
  logic       busy_r, busy_nxt;
  logic       first_r, first_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_pkt_t   out_r;
  logic       load;
  logic       step;

  assign load      = !busy_r && !q_empty;
  assign q_pop     = load;
  assign step      = busy_r && (!out_valid_r || out_take);
  assign out_valid = out_valid_r;
  assign out_pkt   = out_r;

  always_comb begin
    rem_nxt       = rem_r;
    busy_nxt      = busy_r;
    first_nxt     = first_r;
    out_valid_nxt = out_valid_r;
    if (out_take) begin
      out_valid_nxt = 1'b0;
    end
    if (load) begin
      rem_nxt   = q_data.copies;
      busy_nxt  = 1'b1;
      first_nxt = 1'b1;
    end
    if (step) begin
      out_valid_nxt = 1'b1;
      rem_nxt       = rem_r - 1'b1;
      first_nxt     = 1'b0;
      if (rem_r == 4'd1) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r       <= '0;
      busy_r      <= 1'b0;
      first_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rem_r       <= rem_nxt;
      busy_r      <= busy_nxt;
      first_r     <= first_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cmd_r <= q_data;
    end
    if (step) begin
      out_r.event_code       <= cmd_r.event_code;
      out_r.end_flag         <= cmd_r.end_flag;
      out_r.volume           <= cmd_r.volume;
      out_r.duration_samples <= cmd_r.duration_samples;
      out_r.timestamp        <= cmd_r.timestamp;
      out_r.marker           <= cmd_r.marker && first_r;
      out_r.payload_type     <= cmd_r.payload_type;
      out_r.last             <= (rem_r == 4'd1);
    end
  end

endmodule

[src/rtp_dtmf_event_generator.sv]
// ----------------------------------------------------------------------------
// rtp_dtmf_event_generator
// telephony event (dtmf) packet payload generator for one channel
// ----------------------------------------------------------------------------
// usage:
//   input queue: drive in_* and raise in_push; the item is taken at a rising
//   edge with in_push high and in_full low. operation 0 starts a digit,
//   operation 1 is a millisecond tick carrying the current time.
//   result queue: while out_empty is low the oldest packet sits on out_*;
//   raise out_pop to take it. out_last marks the final packet of an item.
//   config: cfg_we writes cfg_wdata into register cfg_index (0 enable,
//   1 payload type, 2 send interval, 3 end copies, 4 max duration); only
//   while the block is idle.
// timing:
//   an item is taken every cycle while the command queue has room. its first
//   packet passes through the command queue and the back end's command
//   register before it shows on out_*. further copies follow one per cycle
//   while out_pop takes them; the next command loads after the last copy.
// reset and stall:
//   reset (rst_n low, synchronous) clears the event state and both queues and
//   loads the register defaults. when out_pop stays low the result register
//   holds, the back end stops, and once the command queue fills in_full rises.
// ----------------------------------------------------------------------------
module rtp_dtmf_event_generator #(
  parameter int CMD_DEPTH = rtpdtmf_pkg::CMD_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration
  input  logic                               cfg_we,
  input  logic [rtpdtmf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rtpdtmf_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // input items
  input  logic                               in_push,
  output logic                               in_full,
  input  logic                               in_operation,
  input  logic [7:0]                         in_digit,
  input  logic [15:0]                        in_duration_ms,
  input  logic [5:0]                         in_volume,
  input  logic [31:0]                        in_now_ms,
  input  logic [31:0]                        in_rtp_timestamp,
  // result items
  output logic                               out_empty,
  input  logic                               out_pop,
  output logic [7:0]                         out_event_code,
  output logic                               out_end_flag,
  output logic [5:0]                         out_event_volume,
  output logic [15:0]                        out_duration_samples,
  output logic [31:0]                        out_packet_timestamp,
  output logic                               out_marker,
  output logic [6:0]                         out_packet_payload_type,
  output logic                               out_last
);
  import rtpdtmf_pkg::*;

  cfg_t     cfg_r;
  logic     in_take;
  logic     cmd_push;
  pkt_cmd_t cmd_wr;
  pkt_cmd_t cmd_rd;
  logic     q_full, q_empty, q_pop;
  logic     out_valid;
  logic     out_take;
  out_pkt_t out_pkt;

  // configuration registers, to be written only while idle; the block does not enforce this
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable        <= RST_ENABLE;
      cfg_r.payload_type  <= RST_PAYLOAD_TYPE;
      cfg_r.send_interval <= RST_SEND_INTERVAL;
      cfg_r.end_count     <= RST_END_COUNT;
      cfg_r.max_duration  <= RST_MAX_DURATION;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ENABLE:        cfg_r.enable        <= cfg_wdata[0];
        REG_PAYLOAD_TYPE:  cfg_r.payload_type  <= cfg_wdata[6:0];
        REG_SEND_INTERVAL: cfg_r.send_interval <= cfg_wdata[9:0];
        REG_END_COUNT:     cfg_r.end_count     <= cfg_wdata[3:0];
        REG_MAX_DURATION:  cfg_r.max_duration  <= cfg_wdata[12:0];
        default: ; // unknown register index, write dropped
      endcase
    end
  end

  // front takes items as long as the command queue has room
  assign in_full = q_full;
  assign in_take = in_push && !q_full;

  rtpdtmf_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .take             (in_take),
    .in_operation     (in_operation),
    .in_digit         (in_digit),
    .in_duration_ms   (in_duration_ms),
    .in_volume        (in_volume),
    .in_now_ms        (in_now_ms),
    .in_rtp_timestamp (in_rtp_timestamp),
    .push             (cmd_push),
    .cmd              (cmd_wr)
  );

  // commands waiting for the back end
  rtpdtmf_queue #(
    .DEPTH (CMD_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (cmd_push),
    .wr_data (cmd_wr),
    .pop     (q_pop),
    .rd_data (cmd_rd),
    .full    (q_full),
    .empty   (q_empty)
  );

  // back end expands copies into the result register
  assign out_take = out_pop && out_valid;

  rtpdtmf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_data    (cmd_rd),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_take  (out_take),
    .out_valid (out_valid),
    .out_pkt   (out_pkt)
  );

  assign out_empty               = !out_valid;
  assign out_event_code          = out_pkt.event_code;
  assign out_end_flag            = out_pkt.end_flag;
  assign out_event_volume        = out_pkt.volume;
  assign out_duration_samples    = out_pkt.duration_samples;
  assign out_packet_timestamp    = out_pkt.timestamp;
  assign out_marker              = out_pkt.marker;
  assign out_packet_payload_type = out_pkt.payload_type;
  assign out_last                = out_pkt.last;

  // nothing is queued while packets are disabled
  a_no_push_disabled: assert property (@(posedge clk) disable iff (!rst_n)
    !cfg_r.enable |-> !cmd_push)
    else $error("command queued while disabled");

  // a queued command always carries at least one copy
  a_push_has_copies: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_push |-> (cmd_wr.copies != 4'd0))
    else $error("command queued with zero copies");

  // the result queue is empty right after reset
  a_empty_after_reset: assert property (@(posedge clk)
    !rst_n |=> out_empty)
    else $error("result present after reset");

  // an item is never taken into a full command queue
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !cmd_push)
    else $error("command pushed into full queue");

endmodule

[verif/dtmf_packet_checker.sv]
// ----------------------------------------------------------------------------
// dtmf_packet_checker
// watches the config port and both queues of the telephony event generator,
// predicts every packet from its own copy of the event state and compares
// each popped packet field by field against the oldest prediction
// ----------------------------------------------------------------------------
module dtmf_packet_checker
  import rtpdtmf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_push,
  input  logic                  in_full,
  input  logic                  in_operation,
  input  logic [7:0]            in_digit,
  input  logic [15:0]           in_duration_ms,
  input  logic [5:0]            in_volume,
  input  logic [31:0]           in_now_ms,
  input  logic [31:0]           in_rtp_timestamp,
  input  logic                  out_empty,
  input  logic                  out_pop,
  input  logic [7:0]            out_event_code,
  input  logic                  out_end_flag,
  input  logic [5:0]            out_event_volume,
  input  logic [15:0]           out_duration_samples,
  input  logic [31:0]           out_packet_timestamp,
  input  logic                  out_marker,
  input  logic [6:0]            out_packet_payload_type,
  input  logic                  out_last,
  output int unsigned           pkt_pending,
  output int unsigned           error_count
);

  localparam logic [31:0] BACKWARD_MS  = 32'd20;
  localparam int          MAX_PER_ITEM = 15;

  // register copies
  logic        cfg_enable;
  logic [6:0]  cfg_pt;
  logic [9:0]  cfg_interval;
  logic [3:0]  cfg_copies;
  logic [12:0] cfg_max_dur;

  // event state
  logic        tone_active;
  logic        marker_due;
  logic [7:0]  tone_digit;
  logic [5:0]  tone_volume;
  logic [15:0] tone_length;
  logic [31:0] tone_begin;
  logic [31:0] tone_finish;
  logic [31:0] tone_rtp_ts;
  logic [31:0] last_tx_ms;

  out_pkt_t    expected_packets[$];
  int unsigned popped;

  initial begin
    error_count = 0;
    pkt_pending = 0;
    popped      = 0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    error_count++;
    $display("[%0t] packet %0d: %s expected 0x%0h got 0x%0h",
             $time, popped, what, want, got);
  endtask

  // forms one packet of the held event, appends its copies
  task automatic form_packets(input logic [31:0] now, input logic force_end,
                              inout int made);
    logic [31:0] elapsed;
    logic        is_end;
    logic        mark;
    int          copies;
    out_pkt_t    pkt;
    if (!cfg_enable) return;
    if (now < tone_begin) begin
      elapsed = BACKWARD_MS;
    end else begin
      elapsed = now - tone_begin;
      elapsed[31:16] = '0;
    end
    is_end = force_end || (elapsed >= {16'd0, tone_length});
    if (is_end) elapsed = {16'd0, tone_length};
    copies = is_end ? int'(cfg_copies) : 1;
    mark = marker_due;
    marker_due = 1'b0;
    for (int i = 0; i < copies && made < MAX_PER_ITEM; i++) begin
      pkt.event_code       = tone_digit;
      pkt.end_flag         = is_end;
      pkt.volume           = tone_volume;
      pkt.duration_samples = {elapsed[12:0], 3'b000};
      pkt.timestamp        = tone_rtp_ts;
      pkt.marker           = mark && (i == 0);
      pkt.payload_type     = cfg_pt;
      pkt.last             = 1'b0;
      expected_packets.insert(expected_packets.size(), pkt);
      made++;
    end
  endtask

  always @(posedge clk) begin : track_items
    out_pkt_t    want;
    logic [15:0] clamped;
    logic [31:0] span;
    int          made;
    if (!rst_n) begin
      cfg_enable   = RST_ENABLE;
      cfg_pt       = RST_PAYLOAD_TYPE;
      cfg_interval = RST_SEND_INTERVAL;
      cfg_copies   = RST_END_COUNT;
      cfg_max_dur  = RST_MAX_DURATION;
      tone_active  = 1'b0;
      marker_due   = 1'b0;
      tone_digit   = '0;
      tone_volume  = '0;
      tone_length  = '0;
      tone_begin   = '0;
      tone_finish  = '0;
      tone_rtp_ts  = '0;
      last_tx_ms   = '0;
      expected_packets.delete();
    end else begin
      // result side first: nothing popped now can stem from this edge's item
      if (!out_empty && out_pop) begin
        popped++;
        if (expected_packets.size() == 0) begin
          report_mismatch("unexpected packet, event_code", 32'd0, {24'd0, out_event_code});
        end else begin
          want = expected_packets.pop_front();
          if (want.event_code !== out_event_code)
            report_mismatch("event_code", want.event_code, out_event_code);
          if (want.end_flag !== out_end_flag)
            report_mismatch("end_flag", want.end_flag, out_end_flag);
          if (want.volume !== out_event_volume)
            report_mismatch("event_volume", want.volume, out_event_volume);
          if (want.duration_samples !== out_duration_samples)
            report_mismatch("duration_samples", want.duration_samples,
                            out_duration_samples);
          if (want.timestamp !== out_packet_timestamp)
            report_mismatch("packet_timestamp", want.timestamp, out_packet_timestamp);
          if (want.marker !== out_marker)
            report_mismatch("marker", want.marker, out_marker);
          if (want.payload_type !== out_packet_payload_type)
            report_mismatch("packet_payload_type", want.payload_type,
                            out_packet_payload_type);
          if (want.last !== out_last)
            report_mismatch("last", want.last, out_last);
        end
      end

      if (cfg_we) begin
        case (cfg_index)
          REG_ENABLE:        cfg_enable   = cfg_wdata[0];
          REG_PAYLOAD_TYPE:  cfg_pt       = cfg_wdata[6:0];
          REG_SEND_INTERVAL: cfg_interval = cfg_wdata[9:0];
          REG_END_COUNT:     cfg_copies   = cfg_wdata[3:0];
          REG_MAX_DURATION:  cfg_max_dur  = cfg_wdata[12:0];
          default: ;
        endcase
      end

      if (in_push && !in_full) begin
        made = 0;
        if (in_operation == OP_START) begin
          clamped = (in_duration_ms > {3'd0, cfg_max_dur}) ? {3'd0, cfg_max_dur}
                                                           : in_duration_ms;
          // a new digit retires the one still sounding
          if (tone_active) form_packets(in_now_ms, 1'b1, made);
          tone_digit  = in_digit;
          tone_volume = in_volume;
          tone_length = clamped;
          tone_begin  = in_now_ms;
          tone_finish = in_now_ms + {16'd0, clamped};
          tone_rtp_ts = in_rtp_timestamp;
          marker_due  = 1'b1;
          tone_active = 1'b1;
        end else if (tone_active) begin
          span = in_now_ms - last_tx_ms;
          if (span[31]) span = 32'd0 - span;
          if (span >= {22'd0, cfg_interval}) begin
            last_tx_ms = in_now_ms;
            if (tone_finish <= in_now_ms) begin
              form_packets(in_now_ms, 1'b1, made);
              tone_active = 1'b0;
            end else begin
              form_packets(in_now_ms, 1'b0, made);
            end
          end
        end
        if (made > 0) begin
          want = expected_packets.pop_back();
          want.last = 1'b1;
          expected_packets.insert(expected_packets.size(), want);
        end
      end
    end
    pkt_pending = expected_packets.size();
  end

endmodule

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// stimulus and verdict for the telephony event generator: directed digits and
// ticks, then random tone sequences over several register settings, with
// bursty pushes and a stalling receiver; the checker does all comparison
// ----------------------------------------------------------------------------
module tb_top;
  import rtpdtmf_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  // quiet margin after the last packet pops, before registers change
  localparam int DRAIN_CYCLES = 100;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_ENABLE;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_push = 1'b0;
  logic                  in_operation = OP_START;
  logic [7:0]            in_digit = '0;
  logic [15:0]           in_duration_ms = '0;
  logic [5:0]            in_volume = '0;
  logic [31:0]           in_now_ms = '0;
  logic [31:0]           in_rtp_timestamp = '0;
  logic                  out_pop = 1'b0;

  logic                  in_full;
  logic                  out_empty;
  logic [7:0]            out_event_code;
  logic                  out_end_flag;
  logic [5:0]            out_event_volume;
  logic [15:0]           out_duration_samples;
  logic [31:0]           out_packet_timestamp;
  logic                  out_marker;
  logic [6:0]            out_packet_payload_type;
  logic                  out_last;

  int unsigned pkt_pending;
  int unsigned mismatches;

  // sender pacing and the software millisecond clock
  int          burst_left = 0;
  logic [31:0] clock_ms = '0;
  int          cur_interval = 50;
  int          cur_max = 8191;

  // receiver stall pattern
  int rx_mode = 0;
  int rx_left = 0;
  int rx_phase = 0;

  int unsigned cycle_count = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  rtp_dtmf_event_generator u_dut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cfg_we                  (cfg_we),
    .cfg_index               (cfg_index),
    .cfg_wdata               (cfg_wdata),
    .in_push                 (in_push),
    .in_full                 (in_full),
    .in_operation            (in_operation),
    .in_digit                (in_digit),
    .in_duration_ms          (in_duration_ms),
    .in_volume               (in_volume),
    .in_now_ms               (in_now_ms),
    .in_rtp_timestamp        (in_rtp_timestamp),
    .out_empty               (out_empty),
    .out_pop                 (out_pop),
    .out_event_code          (out_event_code),
    .out_end_flag            (out_end_flag),
    .out_event_volume        (out_event_volume),
    .out_duration_samples    (out_duration_samples),
    .out_packet_timestamp    (out_packet_timestamp),
    .out_marker              (out_marker),
    .out_packet_payload_type (out_packet_payload_type),
    .out_last                (out_last)
  );

  dtmf_packet_checker u_checker (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cfg_we                  (cfg_we),
    .cfg_index               (cfg_index),
    .cfg_wdata               (cfg_wdata),
    .in_push                 (in_push),
    .in_full                 (in_full),
    .in_operation            (in_operation),
    .in_digit                (in_digit),
    .in_duration_ms          (in_duration_ms),
    .in_volume               (in_volume),
    .in_now_ms               (in_now_ms),
    .in_rtp_timestamp        (in_rtp_timestamp),
    .out_empty               (out_empty),
    .out_pop                 (out_pop),
    .out_event_code          (out_event_code),
    .out_end_flag            (out_end_flag),
    .out_event_volume        (out_event_volume),
    .out_duration_samples    (out_duration_samples),
    .out_packet_timestamp    (out_packet_timestamp),
    .out_marker              (out_marker),
    .out_packet_payload_type (out_packet_payload_type),
    .out_last                (out_last),
    .pkt_pending             (pkt_pending),
    .error_count             (mismatches)
  );

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // receiver: every stretch picks a mode, from always-pop to long stalls
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= $urandom_range(0, 3);
      rx_left <= $urandom_range(16, 160);
    end else begin
      rx_left <= rx_left - 1;
    end
    rx_phase <= rx_phase + 1;
    case (rx_mode)
      0:       out_pop <= 1'b1;
      1:       out_pop <= ($urandom_range(0, 3) != 0);
      2:       out_pop <= ($urandom_range(0, 3) == 0);
      default: out_pop <= ((rx_phase % 11) >= 8);
    endcase
  end

  // push one item; bursts of random length with random gaps in between.
  // returns at the accepting edge with in_push still high, so a following
  // item keeps the line up without a lower-and-raise in one step
  task automatic send_item(input logic op, input logic [7:0] dg,
                           input logic [15:0] dur, input logic [5:0] vol,
                           input logic [31:0] now, input logic [31:0] rts);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        @(negedge clk);
        in_push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_operation     <= op;
    in_digit         <= dg;
    in_duration_ms   <= dur;
    in_volume        <= vol;
    in_now_ms        <= now;
    in_rtp_timestamp <= rts;
    in_push          <= 1'b1;
    do @(posedge clk); while (in_full);
  endtask

  // stop pushing, wait for every predicted packet, then leave a quiet margin
  task automatic let_block_drain();
    @(negedge clk);
    in_push <= 1'b0;
    while (pkt_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
  endtask

  // all five registers, only once the block has gone idle
  task automatic program_regs(input int en, input int pt, input int iv,
                              input int cnt, input int mx);
    let_block_drain();
    write_reg(REG_ENABLE, 13'(en));
    write_reg(REG_PAYLOAD_TYPE, 13'(pt));
    write_reg(REG_SEND_INTERVAL, 13'(iv));
    write_reg(REG_END_COUNT, 13'(cnt));
    write_reg(REG_MAX_DURATION, 13'(mx));
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_interval = iv;
    cur_max      = mx;
  endtask

  // mostly well-formed tones: a start followed by ticks that walk the clock
  // past its end; some tones are cut short by the next start, some ticks run
  // backwards, and the rest is noise with fully random fields
  task automatic random_phase(input int budget);
    int          sent;
    int          ticks;
    int          dur;
    int          eff;
    logic [31:0] tone_ms;
    logic [31:0] span;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(0, 9) < 7) begin
        case ($urandom_range(0, 19))
          0:       dur = $urandom_range(0, 65535);
          1, 2, 3: dur = $urandom_range(0, 8191);
          default: dur = $urandom_range(0, 6 * cur_interval + 40);
        endcase
        eff = (dur > cur_max) ? cur_max : dur;
        send_item(OP_START, 8'($urandom_range(0, 255)), 16'(dur),
                  6'($urandom_range(0, 63)), clock_ms, $urandom());
        sent++;
        tone_ms = clock_ms;
        ticks   = 0;
        span    = 0;
        while (span <= 32'(eff + cur_interval) && ticks < 40 && sent < budget) begin
          // leave it sounding: the next start force-ends it
          if ($urandom_range(0, 24) == 0) break;
          if ($urandom_range(0, 14) == 0)
            clock_ms -= $urandom_range(1, 2 * cur_interval + 30);
          else
            clock_ms += $urandom_range(0, 2 * cur_interval + 4);
          send_item(OP_TICK, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                    6'($urandom_range(0, 63)), clock_ms, $urandom());
          sent++;
          ticks++;
          span = clock_ms - tone_ms;
        end
      end else begin
        case ($urandom_range(0, 3))
          0:       clock_ms = $urandom();
          1:       clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
          default: clock_ms += $urandom_range(0, 4 * cur_interval + 8);
        endcase
        send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                  16'($urandom_range(0, 65535)), 6'($urandom_range(0, 63)),
                  clock_ms, $urandom());
        sent++;
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part: default timing, enabled
    program_regs(1, 0, 50, 3, 8191);
    send_item(OP_TICK,  8'h00, 16'd0,     6'd0,  32'd1000, 32'd0);        // tick while idle
    send_item(OP_START, 8'h00, 16'd100,   6'd0,  32'd1000, 32'd0);
    send_item(OP_TICK,  8'h00, 16'd0,     6'd0,  32'd1020, 32'd0);        // first update, marker
    send_item(OP_TICK,  8'h00, 16'd0,     6'd0,  32'd1040, 32'd0);        // inside interval
    send_item(OP_TICK,  8'h00, 16'd0,     6'd0,  32'd1075, 32'd0);
    send_item(OP_TICK,  8'h00, 16'd0,     6'd0,  32'd1125, 32'd0);        // end copies, retire
    send_item(OP_TICK,  8'h00, 16'd0,     6'd0,  32'd1300, 32'd0);
    // widest digit, volume and timestamp; duration clamps to the maximum
    send_item(OP_START, 8'hFF, 16'hFFFF,  6'd63, 32'd2000, 32'hFFFF_FFFF);
    send_item(OP_TICK,  8'hFF, 16'hFFFF,  6'd63, 32'd2100, 32'hFFFF_FFFF);
    // start while sounding: force-end keeps the old event's timestamp
    send_item(OP_START, 8'h05, 16'd200,   6'd10, 32'd2150, 32'h1234_5678);
    // clock ran backwards past the start: elapsed falls back to twenty ms
    send_item(OP_TICK,  8'h00, 16'd0,     6'd0,  32'd2040, 32'd0);
    send_item(OP_TICK,  8'h00, 16'd0,     6'd0,  32'd2250, 32'd0);
    send_item(OP_TICK,  8'h00, 16'd0,     6'd0,  32'd2400, 32'd0);
    // update that reaches the duration before the end time: end packets,
    // digit stays active until the end time passes
    send_item(OP_START, 8'h07, 16'd10,    6'd33, 32'd5000, 32'hA5A5_A5A5);
    send_item(OP_TICK,  8'h00, 16'd0,     6'd0,  32'd4900, 32'd0);
    send_item(OP_TICK,  8'h00, 16'd0,     6'd0,  32'd5020, 32'd0);
    // end time wraps past zero
    send_item(OP_START, 8'h0B, 16'd100,   6'd1,  32'hFFFF_FFC0, 32'd0);
    send_item(OP_TICK,  8'h00, 16'd0,     6'd0,  32'hFFFF_FFF0, 32'd0);
    // interval difference of exactly half the clock range
    send_item(OP_START, 8'h02, 16'd500,   6'd20, 32'h7FFF_FFF0, 32'd1);
    send_item(OP_TICK,  8'h00, 16'd0,     6'd0,  32'h7FFF_FFF0, 32'd0);
    send_item(OP_TICK,  8'h00, 16'd0,     6'd0,  32'h8001_0000, 32'd0);

    // random part over several settings
    clock_ms = $urandom();
    random_phase(60);
    program_regs(1, 127, 1, 15, 8191);                                   // one-ms interval, most copies
    random_phase(70);
    program_regs(1, $urandom_range(0, 127), 1023, 0, 0);                 // no end copies, zero clamp
    random_phase(40);
    program_regs(0, $urandom_range(0, 127), $urandom_range(1, 200),
                 $urandom_range(0, 15), $urandom_range(0, 8191));        // disabled
    random_phase(40);
    program_regs(1, $urandom_range(0, 127), $urandom_range(1, 1000),
                 $urandom_range(1, 15), $urandom_range(0, 8191));
    random_phase(60);
    program_regs(1, $urandom_range(0, 127), 0, 1, 8191);                 // no interval at all
    random_phase(40);
    program_regs(1, $urandom_range(0, 127), $urandom_range(1, 100),
                 $urandom_range(0, 15), $urandom_range(0, 8191));
    random_phase(50);

    let_block_drain();
    if (mismatches == 0 && pkt_pending == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
